>>> sv/bytecode_image_deframer_core_macros.svh
// assertion helpers shared by the deframer modules
`ifndef BYTECODE_IMAGE_DEFRAMER_CORE_MACROS_SVH
`define BYTECODE_IMAGE_DEFRAMER_CORE_MACROS_SVH

// checked on every clock edge outside reset
`define BID_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define BID_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/bid_pkg.sv
package bid_pkg;

   // request queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // request commands as they arrive
   localparam logic [1:0] CMD_DATA    = 2'd0;
   localparam logic [1:0] CMD_END     = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // image magic, first byte in the low lane
   localparam logic [31:0] MAGIC_WORD = {8'h46, 8'h43, 8'h42, 8'h54};

   localparam logic ERR_EARLY_END = 1'b0;
   localparam logic ERR_MALFORMED = 1'b1;

   typedef enum logic [1:0] {
      TOK_BYTE    = 2'd0,
      TOK_END     = 2'd1,
      TOK_RESTART = 2'd2
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   data;
   } tok_type;

   typedef enum logic [3:0] {
      PH_PREFIX  = 4'd0,
      PH_META    = 4'd1,
      PH_STRLEN  = 4'd2,
      PH_STRBODY = 4'd3,
      PH_ICOUNT  = 4'd4,
      PH_INSTR   = 4'd5,
      PH_KCOUNT  = 4'd6,
      PH_KONST   = 4'd7,
      PH_DONE    = 4'd8,
      PH_ERROR   = 4'd9
   } phase_type;

   typedef enum logic [2:0] {
      REC_ENTRY     = 3'd0,
      REC_STR       = 3'd1,
      REC_INSTR     = 3'd2,
      REC_CONST     = 3'd3,
      REC_CHUNK_END = 3'd4,
      REC_DONE      = 3'd5,
      REC_ERROR     = 3'd6
   } rec_kind_type;

   typedef struct packed {
      rec_kind_type kind;
      logic [31:0]  value_word;
      logic [7:0]   str_char;
      logic [7:0]   opcode;
      logic [7:0]   op_flags;
      logic [15:0]  op_arg;
      logic [7:0]   const_tag;
      logic         closes_group;
      logic         error_code;
   } rec_type;

   // queue handshake from front to queue
   typedef struct packed {
      logic    push;
      tok_type tok;
   } push_type;

endpackage

>>> sv/bid_front.sv
module bid_front (
   input  logic             req_valid,
   input  logic [1:0]       req_cmd,
   input  logic [7:0]       req_data_byte,
   input  logic             queue_full,
   output logic             req_stall,
   output bid_pkg::push_type push
);
   import bid_pkg::*;

   // classify the command; the unused code is taken and dropped
   always_comb begin
      req_stall     = queue_full;
      push.push     = 1'b0;
      push.tok.kind = TOK_BYTE;
      push.tok.data = req_data_byte;
      unique case (req_cmd)
         CMD_DATA: begin
            push.push     = req_valid && !queue_full;
            push.tok.kind = TOK_BYTE;
         end
         CMD_END: begin
            push.push     = req_valid && !queue_full;
            push.tok.kind = TOK_END;
         end
         CMD_RESTART: begin
            push.push     = req_valid && !queue_full;
            push.tok.kind = TOK_RESTART;
         end
         default: begin
            push.push = 1'b0;
         end
      endcase
   end

endmodule

>>> sv/bid_queue.sv
`include "bytecode_image_deframer_core_macros.svh"

module bid_queue (
   input  logic              clock,
   input  logic              reset,
   input  bid_pkg::push_type push,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output bid_pkg::tok_type  head
);
   import bid_pkg::*;

   tok_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = count_ff == QCNT_W'(QDEPTH);
   assign not_empty = count_ff != '0;
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push.push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         entry_ff[wr_ptr_ff] <= push.tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `BID_ASSERT(a_no_pop_empty, pop |-> not_empty, "pop from empty queue")
   `BID_ASSERT(a_no_push_full, push.push |-> !full, "push into full queue")
   `BID_ASSERT(a_count_up, (push.push && !pop) |=> count_ff == $past(count_ff) + QCNT_W'(1),
      "queue count lost a push")
   `BID_ASSERT(a_ptr_gap, count_ff[QPTR_W-1:0] == wr_ptr_ff - rd_ptr_ff,
      "queue pointers disagree with count")

endmodule

>>> sv/bid_back.sv
`include "bytecode_image_deframer_core_macros.svh"

module bid_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             tok_valid,
   input  bid_pkg::tok_type tok,
   output logic             tok_pop,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output bid_pkg::rec_type rsp_rec
);
   import bid_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  byte_index_ff, byte_index_in;
   logic [63:0] assembly_ff, assembly_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [7:0]  held_tag_ff, held_tag_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rec_type     rsp_rec_ff, rsp_rec_in;

   logic        emit;
   rec_type     rec;
   logic [2:0]  slot;
   logic [63:0] ins_word;
   logic [63:0] rem_dec;
   logic        rem_last;
   logic        active;

   assign tok_pop   = tok_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_rec   = rsp_rec_ff;

   always_comb begin
      // constants skip their tag byte in the payload lanes
      slot     = (phase_ff == PH_KONST) ? byte_index_ff - 3'd1 : byte_index_ff;
      ins_word = assembly_ff | (64'(tok.data) << {slot, 3'b000});
      rem_dec  = remaining_ff - 64'd1;
      rem_last = remaining_ff == 64'd1;
      active   = phase_ff != PH_DONE && phase_ff != PH_ERROR;

      phase_in      = phase_ff;
      byte_index_in = byte_index_ff;
      assembly_in   = assembly_ff;
      remaining_in  = remaining_ff;
      held_tag_in   = held_tag_ff;
      emit          = 1'b0;
      rec           = '0;

      if (tok_pop) begin
         unique case (tok.kind)
            TOK_RESTART: begin
               phase_in      = PH_PREFIX;
               byte_index_in = '0;
               assembly_in   = '0;
               remaining_in  = '0;
               held_tag_in   = '0;
            end
            TOK_END: begin
               if (active) begin
                  emit           = 1'b1;
                  rec.kind       = REC_ERROR;
                  rec.error_code = (phase_ff == PH_PREFIX) ? ERR_MALFORMED : ERR_EARLY_END;
                  phase_in       = PH_ERROR;
                  byte_index_in  = '0;
                  assembly_in    = '0;
                  remaining_in   = '0;
               end
            end
            TOK_BYTE: begin
               unique case (phase_ff)
                  PH_PREFIX: begin
                     if (byte_index_ff == 3'd3) begin
                        byte_index_in = '0;
                        assembly_in   = '0;
                        if (ins_word[31:0] == MAGIC_WORD) begin
                           phase_in = PH_META;
                        end else begin
                           emit           = 1'b1;
                           rec.kind       = REC_ERROR;
                           rec.error_code = ERR_MALFORMED;
                           phase_in       = PH_ERROR;
                           remaining_in   = '0;
                        end
                     end else begin
                        assembly_in   = ins_word;
                        byte_index_in = byte_index_ff + 3'd1;
                     end
                  end
                  PH_META: begin
                     if (byte_index_ff == 3'd3) begin
                        emit           = 1'b1;
                        rec.kind       = REC_ENTRY;
                        rec.value_word = ins_word[31:0];
                        phase_in       = PH_STRLEN;
                        byte_index_in  = '0;
                        assembly_in    = '0;
                     end else begin
                        assembly_in   = ins_word;
                        byte_index_in = byte_index_ff + 3'd1;
                     end
                  end
                  PH_STRLEN: begin
                     if (byte_index_ff == 3'd3) begin
                        remaining_in  = {32'd0, ins_word[31:0]};
                        phase_in      = (ins_word[31:0] == '0) ? PH_ICOUNT : PH_STRBODY;
                        byte_index_in = '0;
                        assembly_in   = '0;
                     end else begin
                        assembly_in   = ins_word;
                        byte_index_in = byte_index_ff + 3'd1;
                     end
                  end
                  PH_STRBODY: begin
                     emit             = 1'b1;
                     rec.kind         = REC_STR;
                     rec.str_char     = tok.data;
                     rec.closes_group = rem_last;
                     remaining_in     = rem_dec;
                     if (rem_last) begin
                        phase_in = PH_STRLEN;
                     end
                  end
                  PH_ICOUNT, PH_KCOUNT: begin
                     if (byte_index_ff == 3'd7) begin
                        remaining_in  = ins_word;
                        byte_index_in = '0;
                        assembly_in   = '0;
                        if (ins_word == '0) begin
                           emit     = 1'b1;
                           rec.kind = (phase_ff == PH_ICOUNT) ? REC_DONE : REC_CHUNK_END;
                           phase_in = (phase_ff == PH_ICOUNT) ? PH_DONE : PH_ICOUNT;
                        end else begin
                           phase_in = (phase_ff == PH_ICOUNT) ? PH_INSTR : PH_KONST;
                        end
                     end else begin
                        assembly_in   = ins_word;
                        byte_index_in = byte_index_ff + 3'd1;
                     end
                  end
                  PH_INSTR: begin
                     if (byte_index_ff == 3'd3) begin
                        emit          = 1'b1;
                        rec.kind      = REC_INSTR;
                        rec.opcode    = ins_word[7:0];
                        rec.op_flags  = ins_word[15:8];
                        rec.op_arg    = ins_word[31:16];
                        byte_index_in = '0;
                        assembly_in   = '0;
                        remaining_in  = rem_dec;
                        if (rem_last) begin
                           phase_in = PH_KCOUNT;
                        end
                     end else begin
                        assembly_in   = ins_word;
                        byte_index_in = byte_index_ff + 3'd1;
                     end
                  end
                  PH_KONST: begin
                     if (byte_index_ff == 3'd0) begin
                        held_tag_in   = tok.data;
                        byte_index_in = 3'd1;
                     end else if (byte_index_ff == 3'd4) begin
                        emit             = 1'b1;
                        rec.kind         = REC_CONST;
                        rec.value_word   = ins_word[31:0];
                        rec.const_tag    = held_tag_ff;
                        rec.closes_group = rem_last;
                        byte_index_in    = '0;
                        assembly_in      = '0;
                        held_tag_in      = '0;
                        remaining_in     = rem_dec;
                        if (rem_last) begin
                           phase_in = PH_ICOUNT;
                        end
                     end else begin
                        assembly_in   = ins_word;
                        byte_index_in = byte_index_ff + 3'd1;
                     end
                  end
                  default: begin
                     // finished or failed load ignores data
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      if (tok_pop && emit) begin
         rsp_valid_in = 1'b1;
         rsp_rec_in   = rec;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_rec_in   = rsp_rec_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rec_ff <= rsp_rec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PREFIX;
         byte_index_ff <= '0;
         assembly_ff   <= '0;
         remaining_ff  <= '0;
         held_tag_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
         assembly_ff   <= assembly_in;
         remaining_ff  <= remaining_in;
         held_tag_ff   <= held_tag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   `BID_ASSERT(a_count_live,
      (phase_ff == PH_STRBODY || phase_ff == PH_INSTR || phase_ff == PH_KONST)
      |-> remaining_ff != '0, "item phase entered with zero count")
   `BID_ASSERT(a_error_sticks, (tok_pop && emit && rec.kind == REC_ERROR)
      |=> phase_ff == PH_ERROR, "error record without error phase")
   `BID_ASSERT(a_done_sticks, (tok_pop && emit && rec.kind == REC_DONE)
      |=> phase_ff == PH_DONE, "done record without done phase")
   `BID_ASSERT(a_no_overwrite, (rsp_valid_ff && rsp_stall) |-> !tok_pop,
      "request taken while stalled record waits")

endmodule

>>> sv/bytecode_image_deframer_core.sv
// bytecode image deframer
// the request channel carries one command per request: a data byte, end of
// data, or start of a new load. the image is little endian: magic "TBCF",
// a 32-bit entry id, length-prefixed strings ended by a zero length, then
// chunks of instructions and constants ended by a zero instruction count.
// the response channel carries one record per finished program part:
// entry id, string byte, instruction, constant, empty chunk end, load done
// or error. on an error record the consumer drops the records of the load.
// requests go into a four-entry queue; the parser pops one request per
// cycle into a single response register. an accepted request is written
// into the queue, then parsed from its head, and its record is loaded into
// the response register and shows on rsp_valid until it is taken.
// throughput is one request per cycle; the parser advances whenever the
// response register is empty or being taken, so a stalled receiver holds
// the record steady and the queue fills, raising req_stall when full.
// synchronous reset empties the queue, drops any pending record and puts
// the parser back at the start of a load.
module bytecode_image_deframer_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_rec_kind,
   output logic [31:0] rsp_value_word,
   output logic [7:0]  rsp_str_char,
   output logic [7:0]  rsp_opcode,
   output logic [7:0]  rsp_op_flags,
   output logic [15:0] rsp_op_arg,
   output logic [7:0]  rsp_const_tag,
   output logic        rsp_closes_group,
   output logic        rsp_error_code
);
   import bid_pkg::*;

   push_type push;
   logic     queue_full;
   logic     queue_not_empty;
   tok_type  queue_head;
   logic     queue_pop;
   rec_type  rec;

   // front: decode the command, drop the unused code
   bid_front u_front (
      .req_valid     (req_valid),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .queue_full    (queue_full),
      .req_stall     (req_stall),
      .push          (push)
   );

   // decoupling queue
   bid_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (queue_pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   // back: field state machine and response register
   bid_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (queue_not_empty),
      .tok       (queue_head),
      .tok_pop   (queue_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_rec   (rec)
   );

   // unpack the record onto the response ports
   assign rsp_rec_kind     = rec.kind;
   assign rsp_value_word   = rec.value_word;
   assign rsp_str_char     = rec.str_char;
   assign rsp_opcode       = rec.opcode;
   assign rsp_op_flags     = rec.op_flags;
   assign rsp_op_arg       = rec.op_arg;
   assign rsp_const_tag    = rec.const_tag;
   assign rsp_closes_group = rec.closes_group;
   assign rsp_error_code   = rec.error_code;

endmodule
